[rtl/core/rv32i_instruction_decoder_top_assert.svh]
// Assertion macros shared by the decoder RTL.
`ifndef RV32I_INSTRUCTION_DECODER_TOP_ASSERT_SVH
`define RV32I_INSTRUCTION_DECODER_TOP_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define RVDEC_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error("decoder assertion failed");

// Next-cycle implication, checked out of reset.
`define RVDEC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error("decoder assertion failed");

`endif

[rtl/core/rvdec_pkg.sv]
// Types, codes and the decode function of the RV32I instruction decoder.
package rvdec_pkg;

    typedef logic [31:0]        t_word;
    typedef logic [5:0]         t_mnem;
    typedef logic [4:0]         t_reg;
    typedef logic signed [31:0] t_imm;

    typedef struct packed {
        t_mnem mnem;
        t_imm  imm;
    } t_decode;

    // Major opcodes
    localparam logic [6:0] OP_R      = 7'h33;
    localparam logic [6:0] OP_IMM    = 7'h13;
    localparam logic [6:0] OP_LOAD   = 7'h03;
    localparam logic [6:0] OP_JALR   = 7'h67;
    localparam logic [6:0] OP_STORE  = 7'h23;
    localparam logic [6:0] OP_BRANCH = 7'h63;
    localparam logic [6:0] OP_JAL    = 7'h6F;
    localparam logic [6:0] OP_LUI    = 7'h37;
    localparam logic [6:0] OP_AUIPC  = 7'h17;

    localparam logic [6:0] F7_BASE = 7'h00;
    localparam logic [6:0] F7_ALT  = 7'h20;

    // funct3 values
    localparam logic [2:0] F3_0 = 3'd0;
    localparam logic [2:0] F3_1 = 3'd1;
    localparam logic [2:0] F3_2 = 3'd2;
    localparam logic [2:0] F3_3 = 3'd3;
    localparam logic [2:0] F3_4 = 3'd4;
    localparam logic [2:0] F3_5 = 3'd5;
    localparam logic [2:0] F3_6 = 3'd6;
    localparam logic [2:0] F3_7 = 3'd7;

    // Mnemonic codes
    localparam t_mnem MN_ADD     = 6'd0;
    localparam t_mnem MN_SUB     = 6'd1;
    localparam t_mnem MN_SLL     = 6'd2;
    localparam t_mnem MN_SRL     = 6'd3;
    localparam t_mnem MN_SRA     = 6'd4;
    localparam t_mnem MN_OR      = 6'd5;
    localparam t_mnem MN_XOR     = 6'd6;
    localparam t_mnem MN_AND     = 6'd7;
    localparam t_mnem MN_SLT     = 6'd8;
    localparam t_mnem MN_SLTU    = 6'd9;
    localparam t_mnem MN_ADDI    = 6'd10;
    localparam t_mnem MN_ANDI    = 6'd11;
    localparam t_mnem MN_XORI    = 6'd12;
    localparam t_mnem MN_ORI     = 6'd13;
    localparam t_mnem MN_SLLI    = 6'd14;
    localparam t_mnem MN_SRLI    = 6'd15;
    localparam t_mnem MN_SRAI    = 6'd16;
    localparam t_mnem MN_SLTI    = 6'd17;
    localparam t_mnem MN_SLTIU   = 6'd18;
    localparam t_mnem MN_LW      = 6'd19;
    localparam t_mnem MN_LH      = 6'd20;
    localparam t_mnem MN_LB      = 6'd21;
    localparam t_mnem MN_LBU     = 6'd22;
    localparam t_mnem MN_LHU     = 6'd23;
    localparam t_mnem MN_JALR    = 6'd24;
    localparam t_mnem MN_SW      = 6'd25;
    localparam t_mnem MN_SH      = 6'd26;
    localparam t_mnem MN_SB      = 6'd27;
    localparam t_mnem MN_BEQ     = 6'd28;
    localparam t_mnem MN_BNE     = 6'd29;
    localparam t_mnem MN_BLT     = 6'd30;
    localparam t_mnem MN_BGE     = 6'd31;
    localparam t_mnem MN_BLTU    = 6'd32;
    localparam t_mnem MN_BGEU    = 6'd33;
    localparam t_mnem MN_JAL     = 6'd34;
    localparam t_mnem MN_LUI     = 6'd35;
    localparam t_mnem MN_AUIPC   = 6'd36;
    localparam t_mnem MN_UNKNOWN = 6'd37;

    localparam t_imm IMM_ZERO = 32'sd0;

    function automatic t_decode decode(input t_word w);
        t_decode    d;
        logic [6:0] op;
        logic [2:0] f3;
        logic [6:0] f7;
        t_imm       imm_i;
        t_imm       imm_s;
        t_imm       imm_b;
        t_imm       imm_j;
        t_imm       imm_u;
        t_imm       shamt;
        op    = w[6:0];
        f3    = w[14:12];
        f7    = w[31:25];
        imm_i = {{20{w[31]}}, w[31:20]};
        imm_s = {{20{w[31]}}, w[31:25], w[11:7]};
        imm_b = {{19{w[31]}}, w[31], w[7], w[30:25], w[11:8], 1'b0};
        imm_j = {{11{w[31]}}, w[31], w[19:12], w[20], w[30:21], 1'b0};
        imm_u = {w[31:12], 12'h000};
        shamt = {27'd0, w[24:20]};
        d.mnem = MN_UNKNOWN;
        d.imm  = IMM_ZERO;
        unique case (op)
            OP_R: begin
                if (f7 == F7_BASE) begin
                    unique case (f3)
                        F3_0: d.mnem = MN_ADD;
                        F3_1: d.mnem = MN_SLL;
                        F3_2: d.mnem = MN_SLT;
                        F3_3: d.mnem = MN_SLTU;
                        F3_4: d.mnem = MN_XOR;
                        F3_5: d.mnem = MN_SRL;
                        F3_6: d.mnem = MN_OR;
                        F3_7: d.mnem = MN_AND;
                        default: d.mnem = MN_UNKNOWN;
                    endcase
                end else if (f7 == F7_ALT && f3 == F3_0) begin
                    d.mnem = MN_SUB;
                end else if (f7 == F7_ALT && f3 == F3_5) begin
                    d.mnem = MN_SRA;
                end
            end
            OP_IMM: begin
                // A shift with a bad funct7 is unknown yet still carries the I immediate
                d.imm = imm_i;
                unique case (f3)
                    F3_0: d.mnem = MN_ADDI;
                    F3_1: begin
                        if (f7 == F7_BASE) begin
                            d.mnem = MN_SLLI;
                            d.imm  = shamt;
                        end
                    end
                    F3_2: d.mnem = MN_SLTI;
                    F3_3: d.mnem = MN_SLTIU;
                    F3_4: d.mnem = MN_XORI;
                    F3_5: begin
                        if (f7 == F7_BASE) begin
                            d.mnem = MN_SRLI;
                            d.imm  = shamt;
                        end else if (f7 == F7_ALT) begin
                            d.mnem = MN_SRAI;
                            d.imm  = shamt;
                        end
                    end
                    F3_6: d.mnem = MN_ORI;
                    F3_7: d.mnem = MN_ANDI;
                    default: d.mnem = MN_UNKNOWN;
                endcase
            end
            OP_LOAD: begin
                d.imm = imm_i;
                unique case (f3)
                    F3_0: d.mnem = MN_LB;
                    F3_1: d.mnem = MN_LH;
                    F3_2: d.mnem = MN_LW;
                    F3_4: d.mnem = MN_LBU;
                    F3_5: d.mnem = MN_LHU;
                    default: d.imm = IMM_ZERO;
                endcase
            end
            OP_JALR: begin
                if (f3 == F3_0) begin
                    d.mnem = MN_JALR;
                    d.imm  = imm_i;
                end
            end
            OP_STORE: begin
                d.imm = imm_s;
                unique case (f3)
                    F3_0: d.mnem = MN_SB;
                    F3_1: d.mnem = MN_SH;
                    F3_2: d.mnem = MN_SW;
                    default: d.imm = IMM_ZERO;
                endcase
            end
            OP_BRANCH: begin
                d.imm = imm_b;
                unique case (f3)
                    F3_0: d.mnem = MN_BEQ;
                    F3_1: d.mnem = MN_BNE;
                    F3_4: d.mnem = MN_BLT;
                    F3_5: d.mnem = MN_BGE;
                    F3_6: d.mnem = MN_BLTU;
                    F3_7: d.mnem = MN_BGEU;
                    default: d.imm = IMM_ZERO;
                endcase
            end
            OP_JAL: begin
                d.mnem = MN_JAL;
                d.imm  = imm_j;
            end
            OP_LUI: begin
                d.mnem = MN_LUI;
                d.imm  = imm_u;
            end
            OP_AUIPC: begin
                d.mnem = MN_AUIPC;
                d.imm  = imm_u;
            end
            default: begin
                d.mnem = MN_UNKNOWN;
                d.imm  = IMM_ZERO;
            end
        endcase
        return d;
    endfunction

endpackage

[rtl/core/rv32i_instruction_decoder_top.sv]
// RV32I instruction decoder: input register, decode logic, result register.
// Takes one instruction word per clock while o_in_stall is low and gives one result per word,
// which passes the input register and then the result register. Sustained rate is one word per
// cycle without output stalls, set by the single decode pass between the two registers; each
// stage advances whenever the stage after it is empty or is being taken in the same cycle.
// The instruction index counts every input transfer from zero after reset and wraps at 2^32.
// Register fields are the raw bits of the word for every item; unknown and R-type words
// give a zero immediate, except an OP-IMM shift with an illegal funct7, which carries the
// I-type immediate.
module rv32i_instruction_decoder_top (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  rvdec_pkg::t_word     i_instr_word,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output rvdec_pkg::t_word     o_inst_index,
    output rvdec_pkg::t_mnem     o_mnemonic,
    output rvdec_pkg::t_reg      o_dest_reg,
    output rvdec_pkg::t_reg      o_src1_reg,
    output rvdec_pkg::t_reg      o_src2_reg,
    output rvdec_pkg::t_imm      o_immediate
);
    import rvdec_pkg::*;

    logic    r_count;
    t_word   r_cnt;
    t_word   n_cnt;
    logic    r_s1_valid;
    t_word   r_s1_word;
    t_word   r_s1_index;
    logic    r_out_valid;
    t_word   r_out_index;
    t_mnem   r_out_mnem;
    t_reg    r_out_rd;
    t_reg    r_out_rs1;
    t_reg    r_out_rs2;
    t_imm    r_out_imm;
    logic    w_out_adv;
    logic    w_s1_adv;
    logic    w_in_xfer;
    t_decode w_dec;

    assign w_out_adv = !r_out_valid || !i_out_stall;
    assign w_s1_adv  = !r_s1_valid || w_out_adv;
    assign w_in_xfer = i_in_valid && w_s1_adv;
    assign o_in_stall = !w_s1_adv;
    assign n_cnt = r_cnt + 32'd1;
    assign w_dec = decode(r_s1_word);

    // r_count marks that at least one transfer has been counted since reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt   <= '0;
            r_count <= 1'b0;
        end else if (w_in_xfer) begin
            r_cnt   <= n_cnt;
            r_count <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_s1_adv) begin
            r_s1_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_xfer) begin
            r_s1_word  <= i_instr_word;
            r_s1_index <= r_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_adv) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_adv && r_s1_valid) begin
            r_out_index <= r_s1_index;
            r_out_mnem  <= w_dec.mnem;
            r_out_rd    <= r_s1_word[11:7];
            r_out_rs1   <= r_s1_word[19:15];
            r_out_rs2   <= r_s1_word[24:20];
            r_out_imm   <= w_dec.imm;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_inst_index = r_out_index;
    assign o_mnemonic   = r_out_mnem;
    assign o_dest_reg   = r_out_rd;
    assign o_src1_reg   = r_out_rs1;
    assign o_src2_reg   = r_out_rs2;
    assign o_immediate  = r_out_imm;

`include "rv32i_instruction_decoder_top_assert.svh"

    // The counter steps by exactly one per input transfer
    `RVDEC_ASSERT_NEXT(a_cnt_step, w_in_xfer, r_cnt == $past(n_cnt) && r_count)
    // A full pipe with a stalled output must stall the input
    `RVDEC_ASSERT_NOW(a_full_stall, r_s1_valid && r_out_valid && i_out_stall, o_in_stall)
    // An item moving into the result register keeps its index
    `RVDEC_ASSERT_NEXT(a_idx_move, r_s1_valid && w_out_adv,
        r_out_valid && r_out_index == $past(r_s1_index))
    // Decode never produces a code beyond unknown
    `RVDEC_ASSERT_NOW(a_mnem_range, r_out_valid, r_out_mnem <= MN_UNKNOWN)
    // Register-register ops carry no immediate
    `RVDEC_ASSERT_NOW(a_rtype_imm, r_out_valid && r_out_mnem <= MN_SLTU,
        r_out_imm == IMM_ZERO)

endmodule
